### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the projection block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked at every rising edge of clk, off while rst_n is low
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every rising edge of clk, reset included
`define ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_NOW(lbl, prop, msg)
`endif

`endif

### src/gl_ppm_pkg.sv
// ---------------------------------------------------------------------------
// gl_ppm_pkg
// Types, constants and fixed-point helpers of the camera-to-clip projection
// ---------------------------------------------------------------------------
package gl_ppm_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int RND_W  = PROD_W - FRAC_BITS;
  localparam int DIV_NW = WORD_BITS + 2 * FRAC_BITS + 2;
  localparam int DIV_CW = $clog2(DIV_NW + 1);
  localparam int SAT_W  = ((DIV_NW > PROD_W) ? DIV_NW : PROD_W) + 2;

  localparam int SQ_PER_STG = 2;
  localparam int SQ_STG     = (WORD_BITS + SQ_PER_STG - 1) / SQ_PER_STG;

  localparam int LANES     = 4;
  localparam int ROW_W     = 2;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [RND_W-1:0]     rnd_t;
  typedef logic signed [SAT_W-1:0]     wide_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAR    = 3'd5;

  localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;

  localparam longint FX_ONE     = longint'(1) << FRAC_BITS;
  localparam word_t  RST_LEFT   = word_t'(-FX_ONE);
  localparam word_t  RST_RIGHT  = word_t'(FX_ONE);
  localparam word_t  RST_BOTTOM = word_t'(-FX_ONE);
  localparam word_t  RST_TOP    = word_t'(FX_ONE);
  localparam word_t  RST_NEAR   = word_t'((FX_ONE + 5) / 10);
  localparam word_t  RST_FAR    = word_t'(100 * FX_ONE);

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
  localparam prod_t RND_HALF = prod_t'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] SQ_ONE = PROD_W'(1) << (PROD_W - 2);

  typedef struct packed {
    word_t c0;
    word_t c1;
    word_t c2;
    word_t c3;
  } row_t;

  typedef struct packed {
    row_t r0;
    row_t r1;
    row_t r2;
  } mat_t;

  typedef struct packed {
    word_t o00;
    word_t o03;
    word_t o11;
    word_t o13;
    word_t o22;
    word_t o23;
    word_t k;
    word_t fn;
    logic  err;
  } coef_t;

  typedef struct packed {
    word_t r0;
    word_t r1;
    word_t r2;
    word_t r3;
    logic  err;
  } lane_out_t;

  typedef struct packed {
    logic  err;
    word_t val;
  } sat_t;

  function automatic sat_t sat_word(input wide_t v);
    sat_t s;
    logic [SAT_W-WORD_BITS:0] hi;
    hi = v[SAT_W-1:WORD_BITS-1];
    if (hi == '0 || hi == '1) begin
      s.err = 1'b0;
      s.val = word_t'(v[WORD_BITS-1:0]);
    end else begin
      s.err = 1'b1;
      s.val = v[SAT_W-1] ? WORD_MIN : WORD_MAX;
    end
    return s;
  endfunction

  // exact product of two words
  function automatic prod_t mul_w(input word_t a, input word_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // round half up to FRAC_BITS fraction bits
  function automatic rnd_t rnd_q(input prod_t p);
    prod_t t;
    t = p + RND_HALF;
    return rnd_t'(t[PROD_W-1:FRAC_BITS]);
  endfunction

  function automatic word_t col_of(input row_t r, input int j);
    case (j)
      0:       return r.c0;
      1:       return r.c1;
      2:       return r.c2;
      default: return r.c3;
    endcase
  endfunction

endpackage

### src/gl_ppm_if.sv
// ---------------------------------------------------------------------------
// gl_ppm_if
// Valid/ready channels of the projection block: camera matrix in, rows out
// ---------------------------------------------------------------------------
interface gl_ppm_in_if;
  import gl_ppm_pkg::*;

  logic  valid;
  logic  ready;
  word_t p_r0c0, p_r0c1, p_r0c2, p_r0c3;
  word_t p_r1c0, p_r1c1, p_r1c2, p_r1c3;
  word_t p_r2c0, p_r2c1, p_r2c2, p_r2c3;

  modport source (
    output valid,
    output p_r0c0, p_r0c1, p_r0c2, p_r0c3,
    output p_r1c0, p_r1c1, p_r1c2, p_r1c3,
    output p_r2c0, p_r2c1, p_r2c2, p_r2c3,
    input  ready
  );
  modport sink (
    input  valid,
    input  p_r0c0, p_r0c1, p_r0c2, p_r0c3,
    input  p_r1c0, p_r1c1, p_r1c2, p_r1c3,
    input  p_r2c0, p_r2c1, p_r2c2, p_r2c3,
    output ready
  );
endinterface

interface gl_ppm_out_if;
  import gl_ppm_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  word_t            out_c0, out_c1, out_c2, out_c3;
  logic             last_row;
  logic             range_error;

  modport source (
    output valid, row_index, out_c0, out_c1, out_c2, out_c3, last_row, range_error,
    input  ready
  );
  modport sink (
    input  valid, row_index, out_c0, out_c1, out_c2, out_c3, last_row, range_error,
    output ready
  );
endinterface

### src/gl_ppm_coef.sv
// ---------------------------------------------------------------------------
// gl_ppm_coef
// Window registers and the coefficient unit: six bit-serial divisions for
// the orthographic matrix, then -(far+near) and far*near
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gl_ppm_coef (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gl_ppm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  gl_ppm_pkg::word_t                    cfg_data,
  output gl_ppm_pkg::coef_t                    coef,
  output logic                                 ready
);
  import gl_ppm_pkg::*;

  typedef enum logic [2:0] {ST_LOAD, ST_RUN, ST_FIN, ST_MUL, ST_CLOSE, ST_DONE} state_t;

  localparam logic [2:0] Q_O00 = 3'd0;
  localparam logic [2:0] Q_O03 = 3'd1;
  localparam logic [2:0] Q_O11 = 3'd2;
  localparam logic [2:0] Q_O13 = 3'd3;
  localparam logic [2:0] Q_O22 = 3'd4;
  localparam logic [2:0] Q_O23 = 3'd5;

  localparam logic signed [DIV_NW-1:0] DIV_TWO = DIV_NW'(2) << (2 * FRAC_BITS);

  state_t                state_r;
  logic [2:0]            idx_r;
  logic [DIV_CW-1:0]     cnt_r;
  logic [DIV_NW-1:0]     num_r;
  logic [WORD_BITS:0]    den_r;
  logic [WORD_BITS:0]    rem_r;
  logic [DIV_NW-1:0]     quo_r;
  logic                  neg_r;
  logic                  dzero_r;
  word_t                 left_r, right_r, bottom_r, top_r, near_r, far_r;
  word_t                 q_r [6];
  logic [5:0]            qerr_r;
  prod_t                 prod_r;
  word_t                 k_r, fn_r;
  logic                  kerr_r, fnerr_r;

  logic signed [WORD_BITS:0]  a_w, b_w, sum_w, den_w;
  logic signed [DIV_NW-1:0]   num_w;
  logic [DIV_NW-1:0]          num_mag;
  logic [WORD_BITS:0]         den_mag;
  logic [WORD_BITS+1:0]       rem2;
  logic                       ge;
  logic                       up;
  logic [DIV_NW:0]            qr;
  wide_t                      qs;
  sat_t                       q_sat, k_sat, fn_sat;
  logic                       cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index <= REG_FAR);

  // operands of the current quotient: hi and lo bounds of one axis
  always_comb begin
    a_w = '0;
    b_w = '0;
    case (idx_r)
      Q_O00, Q_O03: begin a_w = {right_r[WORD_BITS-1], right_r};
                          b_w = {left_r[WORD_BITS-1], left_r}; end
      Q_O11, Q_O13: begin a_w = {top_r[WORD_BITS-1], top_r};
                          b_w = {bottom_r[WORD_BITS-1], bottom_r}; end
      default:      begin a_w = {far_r[WORD_BITS-1], far_r};
                          b_w = {near_r[WORD_BITS-1], near_r}; end
    endcase
    sum_w = a_w + b_w;
    case (idx_r)
      Q_O00, Q_O11: begin num_w = DIV_TWO;                       den_w = a_w - b_w; end
      Q_O22:        begin num_w = DIV_TWO;                       den_w = b_w - a_w; end
      default:      begin num_w = DIV_NW'(sum_w) <<< FRAC_BITS;  den_w = b_w - a_w; end
    endcase
    num_mag = num_w[DIV_NW-1] ? DIV_NW'(-num_w) : DIV_NW'(num_w);
    den_mag = den_w[WORD_BITS] ? (WORD_BITS+1)'(-den_w) : (WORD_BITS+1)'(den_w);

    rem2 = {rem_r, num_r[DIV_NW-1]};
    ge   = rem2 >= {1'b0, den_r};
    // round to nearest, halves away from zero: 2*rem >= den
    up   = {rem_r, 1'b0} >= {1'b0, den_r};
    qr   = {1'b0, quo_r} + (DIV_NW+1)'(up);
    qs   = neg_r ? -wide_t'(qr) : wide_t'(qr);
    q_sat  = sat_word(qs);
    k_sat  = sat_word(-(wide_t'(far_r) + wide_t'(near_r)));
    fn_sat = sat_word(wide_t'(rnd_q(prod_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      idx_r    <= '0;
      left_r   <= RST_LEFT;
      right_r  <= RST_RIGHT;
      bottom_r <= RST_BOTTOM;
      top_r    <= RST_TOP;
      near_r   <= RST_NEAR;
      far_r    <= RST_FAR;
    end else begin
      if (cfg_hit) begin
        // any register change restarts the whole coefficient run
        state_r <= ST_LOAD;
        idx_r   <= '0;
      end else begin
        case (state_r)
          ST_LOAD: begin
            num_r   <= num_mag;
            den_r   <= den_mag;
            neg_r   <= num_w[DIV_NW-1] ^ den_w[WORD_BITS];
            dzero_r <= (den_w == '0);
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= DIV_CW'(DIV_NW);
            state_r <= ST_RUN;
          end
          ST_RUN: begin
            rem_r   <= ge ? (WORD_BITS+1)'(rem2 - {1'b0, den_r}) : (WORD_BITS+1)'(rem2);
            quo_r   <= {quo_r[DIV_NW-2:0], ge};
            num_r   <= num_r << 1;
            cnt_r   <= cnt_r - 1'b1;
            if (cnt_r == DIV_CW'(1)) state_r <= ST_FIN;
          end
          ST_FIN: begin
            q_r[idx_r]    <= dzero_r ? '0 : q_sat.val;
            qerr_r[idx_r] <= dzero_r | q_sat.err;
            if (idx_r == Q_O23) begin
              state_r <= ST_MUL;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_LOAD;
            end
          end
          ST_MUL: begin
            prod_r  <= mul_w(far_r, near_r);
            state_r <= ST_CLOSE;
          end
          ST_CLOSE: begin
            fn_r    <= fn_sat.val;
            fnerr_r <= fn_sat.err;
            k_r     <= k_sat.val;
            kerr_r  <= k_sat.err;
            state_r <= ST_DONE;
          end
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT:   left_r   <= cfg_data;
          REG_RIGHT:  right_r  <= cfg_data;
          REG_BOTTOM: bottom_r <= cfg_data;
          REG_TOP:    top_r    <= cfg_data;
          REG_NEAR:   near_r   <= cfg_data;
          REG_FAR:    far_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign coef.o00 = q_r[0];
  assign coef.o03 = q_r[1];
  assign coef.o11 = q_r[2];
  assign coef.o13 = q_r[3];
  assign coef.o22 = q_r[4];
  assign coef.o23 = q_r[5];
  assign coef.k   = k_r;
  assign coef.fn  = fn_r;
  assign coef.err = (|qerr_r) | kerr_r | fnerr_r;
  assign ready    = (state_r == ST_DONE);

  `ASSERT_NOW(a_cfg_drops_ready, (cfg_we && (cfg_index <= REG_FAR)) |=> !ready, "coefficients not rebuilt after write")

endmodule

### src/gl_ppm_root.sv
// ---------------------------------------------------------------------------
// gl_ppm_root
// Pipelined integer square root of the squared length of row 2 (columns 0 to 2),
// carrying the camera matrix alongside
// ---------------------------------------------------------------------------
module gl_ppm_root (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  gl_ppm_pkg::mat_t  in_mat,
  output logic              out_valid,
  output gl_ppm_pkg::word_t norm,
  output logic              norm_err,
  output gl_ppm_pkg::mat_t  out_mat
);
  import gl_ppm_pkg::*;

  logic [WORD_BITS-1:0] mag0, mag1, mag2;
  logic [PROD_W-1:0]    sq_r [3];
  logic [PROD_W-1:0]    sum_r;
  mat_t                 mat1_r, mat2_r;
  logic                 v1_r, v2_r;

  logic [PROD_W-1:0]    op_r  [SQ_STG];
  logic [PROD_W-1:0]    res_r [SQ_STG];
  mat_t                 mat_r [SQ_STG];
  logic                 v_r   [SQ_STG];

  assign mag0 = in_mat.r2.c0[WORD_BITS-1] ? WORD_BITS'(-in_mat.r2.c0) : WORD_BITS'(in_mat.r2.c0);
  assign mag1 = in_mat.r2.c1[WORD_BITS-1] ? WORD_BITS'(-in_mat.r2.c1) : WORD_BITS'(in_mat.r2.c1);
  assign mag2 = in_mat.r2.c2[WORD_BITS-1] ? WORD_BITS'(-in_mat.r2.c2) : WORD_BITS'(in_mat.r2.c2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= PROD_W'(mag0) * PROD_W'(mag0);
      sq_r[1] <= PROD_W'(mag1) * PROD_W'(mag1);
      sq_r[2] <= PROD_W'(mag2) * PROD_W'(mag2);
      mat1_r  <= in_mat;
      sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
      mat2_r  <= mat1_r;
    end
  end

  for (genvar s = 0; s < SQ_STG; s++) begin : g_stg
    logic [PROD_W-1:0] op_in, res_in, op_nxt, res_nxt, one_v, trial;
    logic              v_in;
    mat_t              mat_in;

    if (s == 0) begin : g_first
      assign op_in  = sum_r;
      assign res_in = '0;
      assign v_in   = v2_r;
      assign mat_in = mat2_r;
    end else begin : g_next
      assign op_in  = op_r[s-1];
      assign res_in = res_r[s-1];
      assign v_in   = v_r[s-1];
      assign mat_in = mat_r[s-1];
    end

    // two result bits per stage, digit by digit
    always_comb begin
      op_nxt  = op_in;
      res_nxt = res_in;
      one_v   = '0;
      trial   = '0;
      for (int k = 0; k < SQ_PER_STG; k++) begin
        if (s * SQ_PER_STG + k < WORD_BITS) begin
          one_v = SQ_ONE >> (2 * (s * SQ_PER_STG + k));
          trial = res_nxt + one_v;
          if (op_nxt >= trial) begin
            op_nxt  = op_nxt - trial;
            res_nxt = (res_nxt >> 1) + one_v;
          end else begin
            res_nxt = res_nxt >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op_r[s]  <= op_nxt;
        res_r[s] <= res_nxt;
        mat_r[s] <= mat_in;
      end
    end
  end

  assign out_valid = v_r[SQ_STG-1];
  assign out_mat   = mat_r[SQ_STG-1];
  assign norm_err  = |res_r[SQ_STG-1][PROD_W-1:WORD_BITS-1];
  assign norm      = norm_err ? WORD_MAX : word_t'(res_r[SQ_STG-1][WORD_BITS-1:0]);

endmodule

### src/gl_ppm_lane.sv
// ---------------------------------------------------------------------------
// gl_ppm_lane
// One column of the result: rows 0 and 1 through the ortho matrix, row 2
// scaled, offset and mapped, row 3 copied
// ---------------------------------------------------------------------------
module gl_ppm_lane (
  input  logic                  clk,
  input  logic                  en,
  input  gl_ppm_pkg::word_t     a0,
  input  gl_ppm_pkg::word_t     a1,
  input  gl_ppm_pkg::word_t     a2,
  input  gl_ppm_pkg::coef_t     cf,
  input  gl_ppm_pkg::word_t     addend,
  output gl_ppm_pkg::lane_out_t res
);
  import gl_ppm_pkg::*;

  prod_t pa_r, pb_r, pc_r, pd_r, pk_r, pe_r, pf_r;
  word_t m2_1_r, m2_2_r, m2_3_r, m2_4_r, m2_5_r;
  word_t r0_2_r, r1_2_r, r0_3_r, r1_3_r, r0_4_r, r1_4_r, r0_5_r, r1_5_r;
  rnd_t  kk_2_r;
  word_t b2_3_r, r2_5_r;
  logic  e2_r, e3_r, e4_r, e5_r;

  sat_t  s0, s1, sb, s2;

  always_comb begin
    s0 = sat_word(wide_t'(rnd_q(pa_r)) + wide_t'(rnd_q(pb_r)));
    s1 = sat_word(wide_t'(rnd_q(pc_r)) + wide_t'(rnd_q(pd_r)));
    // the offset joins the scaled entry before saturation
    sb = sat_word(wide_t'(kk_2_r) + wide_t'(addend));
    s2 = sat_word(wide_t'(rnd_q(pe_r)) + wide_t'(rnd_q(pf_r)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= mul_w(cf.o00, a0);
      pb_r   <= mul_w(cf.o03, a2);
      pc_r   <= mul_w(cf.o11, a1);
      pd_r   <= mul_w(cf.o13, a2);
      pk_r   <= mul_w(a2, cf.k);
      m2_1_r <= a2;

      r0_2_r <= s0.val;
      r1_2_r <= s1.val;
      kk_2_r <= rnd_q(pk_r);
      e2_r   <= s0.err | s1.err;
      m2_2_r <= m2_1_r;

      b2_3_r <= sb.val;
      e3_r   <= e2_r | sb.err;
      r0_3_r <= r0_2_r;
      r1_3_r <= r1_2_r;
      m2_3_r <= m2_2_r;

      pe_r   <= mul_w(cf.o22, b2_3_r);
      pf_r   <= mul_w(cf.o23, m2_3_r);
      e4_r   <= e3_r;
      r0_4_r <= r0_3_r;
      r1_4_r <= r1_3_r;
      m2_4_r <= m2_3_r;

      r2_5_r <= s2.val;
      e5_r   <= e4_r | s2.err;
      r0_5_r <= r0_4_r;
      r1_5_r <= r1_4_r;
      m2_5_r <= m2_4_r;
    end
  end

  assign res.r0  = r0_5_r;
  assign res.r1  = r1_5_r;
  assign res.r2  = r2_5_r;
  assign res.r3  = m2_5_r;
  assign res.err = e5_r;

endmodule

### src/gl_ppm_merge.sv
// ---------------------------------------------------------------------------
// gl_ppm_merge
// Gathers the four lane columns into rows and sends them one row per
// transfer; its state sets the advance of the whole pipeline
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gl_ppm_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  gl_ppm_pkg::lane_out_t lanes [gl_ppm_pkg::LANES],
  input  logic                  err_in,
  output logic                  adv,
  gl_ppm_out_if.source          out
);
  import gl_ppm_pkg::*;

  logic             valid_r;
  logic [ROW_W-1:0] row_r;
  row_t             buf_r [4];
  logic             err_r;
  logic             any_err;

  assign adv     = !valid_r || (out.ready && row_r == LAST_ROW);
  assign any_err = err_in | lanes[0].err | lanes[1].err | lanes[2].err | lanes[3].err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      row_r   <= '0;
    end else if (adv) begin
      valid_r <= in_valid;
      row_r   <= '0;
    end else if (out.ready) begin
      row_r   <= row_r + 1'b1;
    end
  end

  // rows shift up after each transfer so row 0 always faces the port
  always_ff @(posedge clk) begin
    if (adv) begin
      buf_r[0] <= '{lanes[0].r0, lanes[1].r0, lanes[2].r0, lanes[3].r0};
      buf_r[1] <= '{lanes[0].r1, lanes[1].r1, lanes[2].r1, lanes[3].r1};
      buf_r[2] <= '{lanes[0].r2, lanes[1].r2, lanes[2].r2, lanes[3].r2};
      buf_r[3] <= '{lanes[0].r3, lanes[1].r3, lanes[2].r3, lanes[3].r3};
      err_r    <= any_err;
    end else if (out.ready) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
      buf_r[2] <= buf_r[3];
    end
  end

  assign out.valid       = valid_r;
  assign out.row_index   = row_r;
  assign out.out_c0      = buf_r[0].c0;
  assign out.out_c1      = buf_r[0].c1;
  assign out.out_c2      = buf_r[0].c2;
  assign out.out_c3      = buf_r[0].c3;
  assign out.last_row    = (row_r == LAST_ROW);
  assign out.range_error = err_r;

  `ASSERT_CHK(a_rows_follow, (out.valid && out.ready && !out.last_row) |=> (out.valid && (out.row_index == $past(out.row_index) + 2'd1)), "row sequence broken")

endmodule

### src/gl_projection_from_camera_matrix.sv
// ---------------------------------------------------------------------------
// gl_projection_from_camera_matrix
// 3x4 camera matrix to 4x4 clip-space projection, signed fixed point
// ---------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  in_ch     in   p_r0c0 .. p_r2c3, 12 x Q15.16             valid/ready
//  out_ch    out  row_index, out_c0..3, last_row, range_err valid/ready
//  cfg_*     in   cfg_index 3b, cfg_data 32b                cfg_we, no wait
//
//  the row serializer sets the pace: a new matrix enters only while it is empty or as
//  its last row transfers; an empty pipeline carries a matrix through the square root,
//  lane and row buffer registers before row 0 transfers. after reset and after each window
//  register write the coefficient unit runs six bit-serial Q15.16 divisions, in_ready low.
//  the whole pipeline advances together; out_ready low stalls every stage while a row waits.
//  reset is synchronous, active low, and restores the register defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gl_projection_from_camera_matrix (
  input  logic                             clk,
  input  logic                             rst_n,
  gl_ppm_in_if.sink                        in_ch,
  gl_ppm_out_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [gl_ppm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  gl_ppm_pkg::word_t                cfg_data
);
  import gl_ppm_pkg::*;

  coef_t     cf;
  logic      cf_ready;
  logic      adv;
  mat_t      in_mat;
  logic      root_valid;
  word_t     root_norm;
  logic      root_err;
  mat_t      root_mat;
  lane_out_t lane_res [LANES];

  prod_t      pfn_r;
  word_t      add_r;
  logic [5:1] v_r;
  logic [5:1] e_r;
  sat_t       add_sat;

  assign in_mat.r0 = '{in_ch.p_r0c0, in_ch.p_r0c1, in_ch.p_r0c2, in_ch.p_r0c3};
  assign in_mat.r1 = '{in_ch.p_r1c0, in_ch.p_r1c1, in_ch.p_r1c2, in_ch.p_r1c3};
  assign in_mat.r2 = '{in_ch.p_r2c0, in_ch.p_r2c1, in_ch.p_r2c2, in_ch.p_r2c3};

  assign in_ch.ready = adv && cf_ready;

  gl_ppm_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (cf),
    .ready     (cf_ready)
  );

  gl_ppm_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_ch.valid && in_ch.ready),
    .in_mat    (in_mat),
    .out_valid (root_valid),
    .norm      (root_norm),
    .norm_err  (root_err),
    .out_mat   (root_mat)
  );

  // far*near*norm, aligned so it reaches the lanes at their offset stage
  assign add_sat = sat_word(wide_t'(rnd_q(pfn_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:1], root_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pfn_r <= mul_w(cf.fn, root_norm);
      add_r <= add_sat.val;
      e_r   <= {e_r[4:3], e_r[2], e_r[1] | add_sat.err, root_err};
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    word_t addend;
    if (j == LANES - 1) begin : g_offs
      assign addend = add_r;
    end else begin : g_zero
      assign addend = '0;
    end

    gl_ppm_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .a0     (col_of(root_mat.r0, j)),
      .a1     (col_of(root_mat.r1, j)),
      .a2     (col_of(root_mat.r2, j)),
      .cf     (cf),
      .addend (addend),
      .res    (lane_res[j])
    );
  end

  gl_ppm_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v_r[5]),
    .lanes    (lane_res),
    .err_in   (e_r[5] | cf.err),
    .adv      (adv),
    .out      (out_ch)
  );

  `ASSERT_CHK(a_stall_holds, (v_r[5] && !adv) |=> v_r[5], "item lost while output stalled")

endmodule

### test/gl_ppm_row_checker.sv
// ---------------------------------------------------------------------------
// gl_ppm_row_checker
// Watches the camera matrix and row channels and the register port, predicts
// the four clip-space rows of every accepted matrix and compares each row
// transfer field by field with the oldest prediction
// ---------------------------------------------------------------------------
module gl_ppm_row_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  gl_ppm_in_if                             in_ch,
  gl_ppm_out_if                            out_ch,
  input  logic                             cfg_we,
  input  logic [gl_ppm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  gl_ppm_pkg::word_t                cfg_data,
  output int                               fail_count,
  output int                               rows_pending
);
  import gl_ppm_pkg::*;

  typedef logic signed [127:0] big_t;

  typedef struct {
    logic [ROW_W-1:0] idx;
    word_t            c[4];
    logic             last;
    logic             err;
  } clip_row_t;

  clip_row_t expected_rows[$];
  word_t     window_reg[6];

  assign rows_pending = expected_rows.size();

  function automatic word_t clamp_word(input big_t v, inout logic e);
    if (v > big_t'(WORD_MAX)) begin
      e = 1'b1;
      return WORD_MAX;
    end
    if (v < big_t'(WORD_MIN)) begin
      e = 1'b1;
      return WORD_MIN;
    end
    return word_t'(v);
  endfunction

  // half up, arithmetic shift
  function automatic big_t round_q(input big_t p);
    return (p + (big_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic word_t fx_mul(input word_t a, input word_t b, inout logic e);
    return clamp_word(round_q(big_t'(a) * big_t'(b)), e);
  endfunction

  // num carries 2*FRAC_BITS fraction bits, den FRAC_BITS; halves away from zero
  function automatic word_t fx_div(input big_t num, input big_t den, inout logic e);
    big_t n, d, q, r;
    logic neg;
    if (den == 0) begin
      e = 1'b1;
      return '0;
    end
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return clamp_word(neg ? -q : q, e);
  endfunction

  function automatic big_t floor_sqrt(input big_t s);
    big_t res, t;
    res = 0;
    for (int i = 63; i >= 0; i--) begin
      t = res | (big_t'(1) <<< i);
      if (t * t <= s) res = t;
    end
    return res;
  endfunction

  task automatic predict_clip_rows(input word_t m[3][4]);
    word_t l, r, bo, tp, nr, fr;
    word_t k, norm, fn, add_term, o00, o03, o11, o13, o22, o23;
    word_t b2[4];
    word_t res[4][4];
    big_t  sq, two;
    logic  e;
    clip_row_t row;
    l = window_reg[REG_LEFT];
    r = window_reg[REG_RIGHT];
    bo = window_reg[REG_BOTTOM];
    tp = window_reg[REG_TOP];
    nr = window_reg[REG_NEAR];
    fr = window_reg[REG_FAR];
    e = 1'b0;
    k = clamp_word(-(big_t'(fr) + big_t'(nr)), e);
    sq = 0;
    for (int j = 0; j < 3; j++) sq = sq + big_t'(m[2][j]) * big_t'(m[2][j]);
    norm = clamp_word(floor_sqrt(sq), e);
    fn = fx_mul(fr, nr, e);
    add_term = fx_mul(fn, norm, e);
    for (int j = 0; j < 3; j++) b2[j] = fx_mul(m[2][j], k, e);
    b2[3] = clamp_word(round_q(big_t'(m[2][3]) * big_t'(k)) + big_t'(add_term), e);
    two = big_t'(2) <<< (2 * FRAC_BITS);
    o00 = fx_div(two, big_t'(r) - big_t'(l), e);
    o03 = fx_div((big_t'(r) + big_t'(l)) <<< FRAC_BITS, big_t'(l) - big_t'(r), e);
    o11 = fx_div(two, big_t'(tp) - big_t'(bo), e);
    o13 = fx_div((big_t'(tp) + big_t'(bo)) <<< FRAC_BITS, big_t'(bo) - big_t'(tp), e);
    o22 = fx_div(two, big_t'(nr) - big_t'(fr), e);
    o23 = fx_div((big_t'(fr) + big_t'(nr)) <<< FRAC_BITS, big_t'(nr) - big_t'(fr), e);
    for (int j = 0; j < 4; j++) begin
      res[0][j] = clamp_word(round_q(big_t'(o00) * big_t'(m[0][j]))
                           + round_q(big_t'(o03) * big_t'(m[2][j])), e);
      res[1][j] = clamp_word(round_q(big_t'(o11) * big_t'(m[1][j]))
                           + round_q(big_t'(o13) * big_t'(m[2][j])), e);
      res[2][j] = clamp_word(round_q(big_t'(o22) * big_t'(b2[j]))
                           + round_q(big_t'(o23) * big_t'(m[2][j])), e);
      res[3][j] = m[2][j];
    end
    for (int i = 0; i < 4; i++) begin
      row.idx = ROW_W'(i);
      for (int j = 0; j < 4; j++) row.c[j] = res[i][j];
      row.last = (ROW_W'(i) == LAST_ROW);
      row.err = e;
      expected_rows.push_back(row);
    end
  endtask

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    fail_count++;
    $display("%0t: row %s mismatch, expected %h, actual %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    word_t     m[3][4];
    clip_row_t want;
    word_t     got[4];
    if (!rst_n) begin
      window_reg[REG_LEFT]   = RST_LEFT;
      window_reg[REG_RIGHT]  = RST_RIGHT;
      window_reg[REG_BOTTOM] = RST_BOTTOM;
      window_reg[REG_TOP]    = RST_TOP;
      window_reg[REG_NEAR]   = RST_NEAR;
      window_reg[REG_FAR]    = RST_FAR;
      expected_rows.delete();
      fail_count = 0;
    end else begin
      if (cfg_we && cfg_index <= REG_FAR) window_reg[cfg_index] = cfg_data;
      if (in_ch.valid && in_ch.ready) begin
        m[0] = '{in_ch.p_r0c0, in_ch.p_r0c1, in_ch.p_r0c2, in_ch.p_r0c3};
        m[1] = '{in_ch.p_r1c0, in_ch.p_r1c1, in_ch.p_r1c2, in_ch.p_r1c3};
        m[2] = '{in_ch.p_r2c0, in_ch.p_r2c1, in_ch.p_r2c2, in_ch.p_r2c3};
        predict_clip_rows(m);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rows.size() == 0) begin
          fail_count++;
          $display("%0t: row transfer with none expected, actual row %0d",
                   $time, out_ch.row_index);
        end else begin
          want = expected_rows.pop_front();
          got = '{out_ch.out_c0, out_ch.out_c1, out_ch.out_c2, out_ch.out_c3};
          if (out_ch.row_index !== want.idx) report("index", want.idx, out_ch.row_index);
          for (int j = 0; j < 4; j++)
            if (got[j] !== want.c[j]) report($sformatf("col %0d", j), want.c[j], got[j]);
          if (out_ch.last_row !== want.last) report("last", want.last, out_ch.last_row);
          if (out_ch.range_error !== want.err) report("error", want.err, out_ch.range_error);
        end
      end
    end
  end

endmodule

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives camera matrices and window settings into the projection block
// under random sender and receiver gaps, and gives the verdict from the
// checker's failure count
// ---------------------------------------------------------------------------
module tb_top;
  import gl_ppm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  word_t cfg_data = '0;
  int fail_count, rows_pending;
  int tx_idle_pct = 0, rx_idle_pct = 0, rx_hold_left = 0;
  logic rx_hold_go = 1'b0;
  logic rx_hold_used = 1'b0;
  int cycle_count = 0;

  gl_ppm_in_if  in_ch ();
  gl_ppm_out_if out_ch ();

  gl_projection_from_camera_matrix uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gl_ppm_row_checker row_check (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .rows_pending(rows_pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rx_hold_go && !rx_hold_used) begin
      rx_hold_used = 1'b1;
      rx_hold_left = 400;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(4))
      0, 1:    return word_t'($urandom);
      2:       return word_t'($urandom_range(262143)) - word_t'(131072);
      3:       return $urandom_range(1) ? WORD_MAX : WORD_MIN;
      default: return word_t'($urandom_range(8191)) - word_t'(4096);
    endcase
  endfunction

  task automatic send_matrix(input word_t v[12]);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    {in_ch.p_r0c0, in_ch.p_r0c1, in_ch.p_r0c2, in_ch.p_r0c3} = {v[0], v[1], v[2], v[3]};
    {in_ch.p_r1c0, in_ch.p_r1c1, in_ch.p_r1c2, in_ch.p_r1c3} = {v[4], v[5], v[6], v[7]};
    {in_ch.p_r2c0, in_ch.p_r2c1, in_ch.p_r2c2, in_ch.p_r2c3} = {v[8], v[9], v[10], v[11]};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_random(input int count);
    word_t v[12];
    repeat (count) begin
      foreach (v[i]) v[i] = pick_word();
      send_matrix(v);
    end
  endtask

  // written only once all rows are out and the pipeline has emptied
  task automatic set_window(input word_t l, input word_t r, input word_t b,
                            input word_t t, input word_t n, input word_t f);
    word_t vals[6];
    vals = '{l, r, b, t, n, f};
    while (rows_pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_we = 1'b1;
      cfg_index = CFG_IDX_W'(i);
      cfg_data = vals[i];
      @(negedge clk);
    end
    cfg_index = REG_UNUSED;
    cfg_data = word_t'($urandom);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    word_t v[12];
    in_ch.valid = 1'b0;
    {in_ch.p_r0c0, in_ch.p_r0c1, in_ch.p_r0c2, in_ch.p_r0c3} = '0;
    {in_ch.p_r1c0, in_ch.p_r1c1, in_ch.p_r1c2, in_ch.p_r1c3} = '0;
    {in_ch.p_r2c0, in_ch.p_r2c1, in_ch.p_r2c2, in_ch.p_r2c3} = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed under reset defaults: zeros, extremes, a typical camera
    v = '{default: '0};
    send_matrix(v);
    v = '{default: WORD_MAX};
    send_matrix(v);
    v = '{default: WORD_MIN};
    send_matrix(v);
    v = '{32'sh0064_0000, 0, 32'sh0140_0000, 0, 0, 32'sh0064_0000, 32'sh00F0_0000, 0,
          0, 0, 32'sh0001_0000, 0};
    send_matrix(v);
    // 3x3 camera, column 3 zero
    v = '{32'sh0002_0000, 32'sh0000_8000, 0, 0, 0, 32'sh0002_0000, 32'sh0000_4000, 0,
          32'sh0000_1000, 32'sh0000_2000, 32'sh0001_0000, 0};
    send_matrix(v);
    send_random(3);

    // zero denominators on all three axes
    set_window(32'sh0001_0000, 32'sh0001_0000, -32'sh0002_0000, -32'sh0002_0000,
               32'sh0000_8000, 32'sh0000_8000);
    send_random(4);
    // widest window, register extremes
    set_window(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
    send_random(4);
    set_window(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX);
    send_random(4);

    // eager sender, busy receiver, with one long hold-off to fill the pipe
    set_window(-32'sh0000_C000, 32'sh0001_4000, -32'sh0000_8000, 32'sh0000_A000,
               32'sh0000_199A, 32'sh0032_0000);
    tx_idle_pct = 20;
    rx_idle_pct = 74;
    rx_hold_go = 1'b1;
    send_random(64);

    set_window(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
    tx_idle_pct = 74;
    rx_idle_pct = 20;
    send_random(64);

    set_window(word_t'($urandom), word_t'($urandom), word_t'($urandom),
               word_t'($urandom), word_t'($urandom), word_t'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(64);

    while (rows_pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/gl_ppm_pkg.sv
src/gl_ppm_if.sv
src/gl_ppm_coef.sv
src/gl_ppm_root.sv
src/gl_ppm_lane.sv
src/gl_ppm_merge.sv
src/gl_projection_from_camera_matrix.sv
test/gl_ppm_row_checker.sv
test/tb_top.sv
